// File: rtl/core/css_pkg.sv
// Package for the comment stripper: character codes, the queue depth, the count type and the result item type.
`default_nettype none
package css_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int QUEUE_DEPTH = 3;

  typedef logic [1:0] qcount_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/comment_stripper_stream.sv
// Quote-aware comment stripper for a byte stream with line-end items.
//
// Input channel: in_valid/in_stall with in_byte and line_end. An item with
// line_end set is an end-of-line event and its in_byte is ignored. Output
// channel: out_valid/out_stall with out_byte and last_of_run; last_of_run
// marks the last result caused by one input item.
// Each byte is decided when the next item arrives (one-byte lookahead), so
// a character item yields its kept byte one item later; a line end yields
// the decided held byte, if kept, and then a newline.
// Results are registered into a three-entry output queue. One input item is
// taken per cycle while in_stall is low; a line end that yields two results
// puts both into the queue at once.
// in_stall is high when two or more results wait in the queue, so the
// input keeps moving while one result waits on a stalled receiver.
// Reset clears the held byte, all comment and quote flags and the queue.
// While out_stall is high the head result holds and the queue fills.
`default_nettype none
module comment_stripper_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       line_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic       block_open, block_open_next;
  logic       single_quoted, single_quoted_next;
  logic       double_quoted, double_quoted_next;
  logic       rest_dropped, rest_dropped_next;

  css_pkg::result_t queue [css_pkg::QUEUE_DEPTH];
  css_pkg::result_t queue_next [css_pkg::QUEUE_DEPTH];
  css_pkg::qcount_t count, count_next, count_after;

  logic       accept, pop;
  logic [7:0] dec_nx;
  logic       dec_take, consumed, emit;
  logic       bo_d, sq_d, dq_d, rd_d;
  logic [1:0] n_res;
  css_pkg::result_t res0, res1;

  assign in_stall    = (count > 2'd1);
  assign accept      = in_valid && !in_stall;
  assign out_valid   = (count != 2'd0);
  assign pop         = out_valid && !out_stall;
  assign out_byte    = queue[0].out_byte;
  assign last_of_run = queue[0].last_of_run;

  // decide the held byte against its lookahead
  assign dec_nx   = line_end ? css_pkg::CH_NUL : in_byte;
  assign dec_take = held_valid && !rest_dropped;

  always_comb begin
    consumed = 1'b0;
    emit     = 1'b0;
    bo_d     = block_open;
    sq_d     = single_quoted;
    dq_d     = double_quoted;
    rd_d     = rest_dropped;
    priority if (block_open) begin
      if (held_byte == css_pkg::CH_STAR && dec_nx == css_pkg::CH_SLASH) begin
        bo_d     = 1'b0;
        consumed = 1'b1;
      end
    end else if (!single_quoted && !double_quoted && held_byte == css_pkg::CH_SLASH &&
                 dec_nx == css_pkg::CH_STAR) begin
      bo_d     = 1'b1;
      consumed = 1'b1;
    end else if (held_byte == css_pkg::CH_SQUOTE && !double_quoted) begin
      sq_d = !single_quoted;
      emit = 1'b1;
    end else if (held_byte == css_pkg::CH_DQUOTE && !single_quoted) begin
      dq_d = !double_quoted;
      emit = 1'b1;
    end else if ((held_byte == css_pkg::CH_HASH || held_byte == css_pkg::CH_SEMI) &&
                 !single_quoted && !double_quoted) begin
      rd_d = 1'b1;
    end else begin
      emit = 1'b1;
    end
  end

  always_comb begin
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    block_open_next    = block_open;
    single_quoted_next = single_quoted;
    double_quoted_next = double_quoted;
    rest_dropped_next  = rest_dropped;
    n_res              = 2'd0;
    res0               = '{out_byte: css_pkg::CH_NL, last_of_run: 1'b1};
    res1               = '{out_byte: css_pkg::CH_NL, last_of_run: 1'b1};
    if (accept) begin
      priority if (line_end) begin
        if (dec_take) begin
          block_open_next = bo_d;
        end
        if (dec_take && emit) begin
          res0  = '{out_byte: held_byte, last_of_run: 1'b0};
          n_res = 2'd2;
        end else begin
          n_res = 2'd1;
        end
        held_byte_next     = '0;
        held_valid_next    = 1'b0;
        single_quoted_next = 1'b0;
        double_quoted_next = 1'b0;
        rest_dropped_next  = 1'b0;
      end else if (rest_dropped) begin
        // drop the item
      end else if (!held_valid) begin
        held_byte_next  = in_byte;
        held_valid_next = 1'b1;
      end else begin
        block_open_next    = bo_d;
        single_quoted_next = sq_d;
        double_quoted_next = dq_d;
        rest_dropped_next  = rd_d;
        if (consumed || rd_d) begin
          held_byte_next  = '0;
          held_valid_next = 1'b0;
        end else begin
          held_byte_next  = in_byte;
          held_valid_next = 1'b1;
        end
        if (emit) begin
          res0  = '{out_byte: held_byte, last_of_run: 1'b1};
          n_res = 2'd1;
        end
      end
    end
  end

  // advance the output queue, then append new results
  always_comb begin
    count_after = count - css_pkg::qcount_t'(pop);
    for (int i = 0; i < css_pkg::QUEUE_DEPTH; i++) begin
      queue_next[i] = queue[i];
    end
    if (pop) begin
      for (int i = 0; i < css_pkg::QUEUE_DEPTH - 1; i++) begin
        queue_next[i] = queue[i + 1];
      end
    end
    for (int i = 0; i < css_pkg::QUEUE_DEPTH; i++) begin
      if (n_res != 2'd0 && count_after == css_pkg::qcount_t'(i)) begin
        queue_next[i] = res0;
      end
      if (n_res == 2'd2 && count_after + 2'd1 == css_pkg::qcount_t'(i)) begin
        queue_next[i] = res1;
      end
    end
    count_next = count_after + n_res;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < css_pkg::QUEUE_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
    if (rst) begin
      count         <= '0;
      held_byte     <= '0;
      held_valid    <= 1'b0;
      block_open    <= 1'b0;
      single_quoted <= 1'b0;
      double_quoted <= 1'b0;
      rest_dropped  <= 1'b0;
    end else begin
      count         <= count_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      block_open    <= block_open_next;
      single_quoted <= single_quoted_next;
      double_quoted <= double_quoted_next;
      rest_dropped  <= rest_dropped_next;
    end
  end

endmodule
`default_nettype wire
